FILE: rtl/rwcp_pkg.sv
`timescale 1ns / 1ps

package rwcp_pkg;

    localparam int DATA_W      = 144;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = 2;
    localparam int CNT_W       = 3;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam int FMT_MIN  = 16;
    localparam int FILE_HDR = 12;

    localparam logic [3:0] FMT_LAST_OFF  = 4'd15;
    localparam logic [3:0] HDR_LAST_POS  = 4'd11;
    localparam logic [3:0] SEEN_MAX      = 4'd13;

    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_REPORT  = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_NO_FMT     = 2'd2;
    localparam logic [1:0] ST_NO_DATA    = 2'd3;

    typedef enum logic [3:0] {
        PH_FILE = 4'b0001,
        PH_HDR  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_PAD  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic              last;
        logic              user;
        logic [DATA_W-1:0] data;
    } word_t;

    typedef struct packed {
        logic  pay_valid;
        word_t pay;
        logic  rpt_valid;
        word_t rpt;
    } push_t;

endpackage

FILE: rtl/rwcp_parser.sv
`timescale 1ns / 1ps

module rwcp_parser #(
    parameter int SIZE_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         file_byte,
    input  logic               end_of_file,
    output rwcp_pkg::push_t    push
);

    localparam logic [SIZE_BITS-1:0] FMT_MIN_S = SIZE_BITS'(rwcp_pkg::FMT_MIN);
    localparam logic [SIZE_BITS-1:0] ONE_S     = SIZE_BITS'(1);

    logic [3:0]            bytes_seen_reg,  bytes_seen_next;
    logic                  header_good_reg, header_good_next;
    rwcp_pkg::phase_t      phase_reg,       phase_next;
    logic [2:0]            hdr_index_reg,   hdr_index_next;
    logic [31:0]           id_reg,          id_next;
    logic [SIZE_BITS-1:0]  size_reg,        size_next;
    logic [SIZE_BITS-1:0]  remain_reg,      remain_next;
    logic                  pad_reg,         pad_next;
    logic                  fmt_ok_reg,      fmt_ok_next;
    logic                  is_data_reg,     is_data_next;
    logic [4:0]            body_cnt_reg,    body_cnt_next;
    logic [15:0]           tag_reg,         tag_next;
    logic [15:0]           chans_reg,       chans_next;
    logic [31:0]           rate_reg,        rate_next;
    logic [31:0]           brate_reg,       brate_next;
    logic [15:0]           align_reg,       align_next;
    logic [15:0]           bits_reg,        bits_next;
    logic                  have_fmt_reg,    have_fmt_next;
    logic                  have_data_reg,   have_data_next;

    logic [7:0]            staging [15];
    logic                  stage_we;
    logic [1:0]            tag_sel;
    logic [31:0]           tag_word;
    logic [7:0]            tag_byte;
    logic [1:0]            status;

    always_comb
    begin
        bytes_seen_next  = bytes_seen_reg;
        header_good_next = header_good_reg;
        phase_next       = phase_reg;
        hdr_index_next   = hdr_index_reg;
        id_next          = id_reg;
        size_next        = size_reg;
        remain_next      = remain_reg;
        pad_next         = pad_reg;
        fmt_ok_next      = fmt_ok_reg;
        is_data_next     = is_data_reg;
        body_cnt_next    = body_cnt_reg;
        tag_next         = tag_reg;
        chans_next       = chans_reg;
        rate_next        = rate_reg;
        brate_next       = brate_reg;
        align_next       = align_reg;
        bits_next        = bits_reg;
        have_fmt_next    = have_fmt_reg;
        have_data_next   = have_data_reg;
        stage_we         = 1'b0;
        status           = rwcp_pkg::ST_OK;
        push             = '0;

        tag_sel  = 2'd3 - bytes_seen_reg[1:0];
        tag_word = (bytes_seen_reg < 4'd4) ? rwcp_pkg::TAG_RIFF : rwcp_pkg::TAG_WAVE;
        tag_byte = tag_word[{tag_sel, 3'b000} +: 8];

        case (phase_reg)
            rwcp_pkg::PH_FILE:
            begin
                if ((bytes_seen_reg < 4'd4) || (bytes_seen_reg >= 4'd8))
                begin
                    if (tag_byte != file_byte)
                    begin
                        header_good_next = 1'b0;
                    end
                end
                if (bytes_seen_reg == rwcp_pkg::HDR_LAST_POS)
                begin
                    phase_next     = rwcp_pkg::PH_HDR;
                    hdr_index_next = 3'd0;
                end
            end
            rwcp_pkg::PH_HDR:
            begin
                if (!hdr_index_reg[2])
                begin
                    id_next = {id_reg[23:0], file_byte};
                    if (hdr_index_reg == 3'd0)
                    begin
                        size_next = '0;
                    end
                end
                else
                begin
                    size_next = size_reg |
                        SIZE_BITS'(32'(file_byte) << {hdr_index_reg[1:0], 3'b000});
                end
                hdr_index_next = hdr_index_reg + 3'd1;
                if (hdr_index_reg == 3'd7)
                begin
                    remain_next   = size_next;
                    pad_next      = size_next[0];
                    is_data_next  = (id_reg == rwcp_pkg::TAG_DATA);
                    fmt_ok_next   = (id_reg == rwcp_pkg::TAG_FMT) && (size_next >= FMT_MIN_S);
                    body_cnt_next = 5'd0;
                    if (id_reg == rwcp_pkg::TAG_DATA)
                    begin
                        have_data_next = 1'b1;
                    end
                    phase_next = (size_next == '0) ? rwcp_pkg::PH_HDR : rwcp_pkg::PH_BODY;
                end
            end
            rwcp_pkg::PH_BODY:
            begin
                if (fmt_ok_reg && !body_cnt_reg[4])
                begin
                    stage_we = 1'b1;
                    if (body_cnt_reg[3:0] == rwcp_pkg::FMT_LAST_OFF)
                    begin
                        tag_next      = {staging[1], staging[0]};
                        chans_next    = {staging[3], staging[2]};
                        rate_next     = {staging[7], staging[6], staging[5], staging[4]};
                        brate_next    = {staging[11], staging[10], staging[9], staging[8]};
                        align_next    = {staging[13], staging[12]};
                        bits_next     = {file_byte, staging[14]};
                        have_fmt_next = 1'b1;
                    end
                end
                else if (is_data_reg && header_good_reg)
                begin
                    push.pay_valid      = accept;
                    push.pay.last       = rwcp_pkg::KIND_PAYLOAD;
                    push.pay.user       = (body_cnt_reg == 5'd0);
                    push.pay.data[7:0]  = file_byte;
                end
                if (!body_cnt_reg[4])
                begin
                    body_cnt_next = body_cnt_reg + 5'd1;
                end
                remain_next = remain_reg - ONE_S;
                if (remain_reg == ONE_S)
                begin
                    phase_next     = pad_reg ? rwcp_pkg::PH_PAD : rwcp_pkg::PH_HDR;
                    hdr_index_next = 3'd0;
                end
            end
            rwcp_pkg::PH_PAD:
            begin
                phase_next     = rwcp_pkg::PH_HDR;
                hdr_index_next = 3'd0;
            end
            default:
            begin
                phase_next = rwcp_pkg::PH_FILE;
            end
        endcase

        if (bytes_seen_reg != rwcp_pkg::SEEN_MAX)
        begin
            bytes_seen_next = bytes_seen_reg + 4'd1;
        end

        if (end_of_file)
        begin
            if (!header_good_next || (bytes_seen_next <= 4'(rwcp_pkg::FILE_HDR)))
            begin
                status = rwcp_pkg::ST_BAD_HEADER;
            end
            else if (!have_fmt_next)
            begin
                status = rwcp_pkg::ST_NO_FMT;
            end
            else if (!have_data_next)
            begin
                status = rwcp_pkg::ST_NO_DATA;
            end
            else
            begin
                status = rwcp_pkg::ST_OK;
            end
            push.rpt_valid = accept;
            push.rpt.last  = rwcp_pkg::KIND_REPORT;
            push.rpt.user  = 1'b0;
            if (status != rwcp_pkg::ST_BAD_HEADER)
            begin
                push.rpt.data[23:8]    = tag_next;
                push.rpt.data[39:24]   = chans_next;
                push.rpt.data[71:40]   = rate_next;
                push.rpt.data[103:72]  = brate_next;
                push.rpt.data[119:104] = align_next;
                push.rpt.data[135:120] = bits_next;
            end
            push.rpt.data[137:136] = status;

            bytes_seen_next  = 4'd0;
            header_good_next = 1'b1;
            phase_next       = rwcp_pkg::PH_FILE;
            hdr_index_next   = 3'd0;
            id_next          = '0;
            size_next        = '0;
            remain_next      = '0;
            pad_next         = 1'b0;
            fmt_ok_next      = 1'b0;
            is_data_next     = 1'b0;
            body_cnt_next    = 5'd0;
            tag_next         = '0;
            chans_next       = '0;
            rate_next        = '0;
            brate_next       = '0;
            align_next       = '0;
            bits_next        = '0;
            have_fmt_next    = 1'b0;
            have_data_next   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && stage_we && (body_cnt_reg[3:0] != rwcp_pkg::FMT_LAST_OFF))
        begin
            staging[body_cnt_reg[3:0]] <= file_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg  <= 4'd0;
            header_good_reg <= 1'b1;
            phase_reg       <= rwcp_pkg::PH_FILE;
            hdr_index_reg   <= 3'd0;
            id_reg          <= '0;
            size_reg        <= '0;
            remain_reg      <= '0;
            pad_reg         <= 1'b0;
            fmt_ok_reg      <= 1'b0;
            is_data_reg     <= 1'b0;
            body_cnt_reg    <= 5'd0;
            tag_reg         <= '0;
            chans_reg       <= '0;
            rate_reg        <= '0;
            brate_reg       <= '0;
            align_reg       <= '0;
            bits_reg        <= '0;
            have_fmt_reg    <= 1'b0;
            have_data_reg   <= 1'b0;
        end
        else if (accept)
        begin
            bytes_seen_reg  <= bytes_seen_next;
            header_good_reg <= header_good_next;
            phase_reg       <= phase_next;
            hdr_index_reg   <= hdr_index_next;
            id_reg          <= id_next;
            size_reg        <= size_next;
            remain_reg      <= remain_next;
            pad_reg         <= pad_next;
            fmt_ok_reg      <= fmt_ok_next;
            is_data_reg     <= is_data_next;
            body_cnt_reg    <= body_cnt_next;
            tag_reg         <= tag_next;
            chans_reg       <= chans_next;
            rate_reg        <= rate_next;
            brate_reg       <= brate_next;
            align_reg       <= align_next;
            bits_reg        <= bits_next;
            have_fmt_reg    <= have_fmt_next;
            have_data_reg   <= have_data_next;
        end
    end

endmodule

FILE: rtl/rwcp_out_queue.sv
`timescale 1ns / 1ps

module rwcp_out_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rwcp_pkg::push_t              push,
    output logic                         room,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rwcp_pkg::DATA_W-1:0]  m_tdata,
    output logic                         m_tlast,
    output logic                         m_tuser
);

    rwcp_pkg::word_t                 mem [rwcp_pkg::QUEUE_DEPTH];
    logic [rwcp_pkg::PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [rwcp_pkg::PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [rwcp_pkg::CNT_W-1:0]      count_reg,  count_next;
    logic [rwcp_pkg::PTR_W-1:0]      rpt_ptr;
    logic                            pop;

    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign room     = (count_reg <= rwcp_pkg::CNT_W'(rwcp_pkg::QUEUE_DEPTH - 2));
    assign rpt_ptr  = wr_ptr_reg + rwcp_pkg::PTR_W'(push.pay_valid);

    assign m_tdata  = mem[rd_ptr_reg].data;
    assign m_tlast  = mem[rd_ptr_reg].last;
    assign m_tuser  = mem[rd_ptr_reg].user;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + rwcp_pkg::PTR_W'(push.pay_valid)
                                 + rwcp_pkg::PTR_W'(push.rpt_valid);
        rd_ptr_next = rd_ptr_reg + rwcp_pkg::PTR_W'(pop);
        count_next  = count_reg + rwcp_pkg::CNT_W'(push.pay_valid)
                                + rwcp_pkg::CNT_W'(push.rpt_valid)
                                - rwcp_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.pay_valid)
        begin
            mem[wr_ptr_reg] <= push.pay;
        end
        if (push.rpt_valid)
        begin
            mem[rpt_ptr] <= push.rpt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rwcp_pkg::CNT_W'(rwcp_pkg::QUEUE_DEPTH))
        else $error("output queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.pay_valid || push.rpt_valid) |-> room)
        else $error("word pushed without room");

    a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
        push.rpt_valid |-> (push.rpt.last && !push.rpt.user))
        else $error("report word not marked last");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push.pay_valid && push.rpt_valid && !pop) |=> (count_reg == $past(count_reg) + 3'd2))
        else $error("queue count lost a word");

endmodule

FILE: rtl/riff_wave_chunk_parser.sv
`timescale 1ns / 1ps

// riff/wave chunk parser
// slave side takes one file byte per word, tlast on the final byte of the file
// master side gives data chunk payload bytes (tlast low, tuser marks the first
// byte of each data chunk) and one end-of-file report word with tlast high,
// carrying the captured fmt fields and a status code
// with the output queue empty, a word appears on the master side in the
// cycle after its byte is taken
// throughput: one byte per cycle while s_tready is high; a byte that yields both a
// payload word and the report fills two slots of the four-word output queue
// s_tready stays high while at most two words wait, so a stalled receiver lets
// the block keep taking bytes until the queue holds three or four words
// reset clears the parser to the start of a file and empties the queue;
// s_tready is high while the queue is empty, so also right after reset
// after each report the parser returns to the start of a file by itself
// chunk sizes are taken modulo 2^SIZE_BITS

module riff_wave_chunk_parser #(
    parameter int SIZE_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // file_byte
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [143:0] m_tdata,    // payload_byte, format_tag, channel_count, sample_rate,
                                     // byte_rate, block_align, sample_bits, status, zero fill
    output logic         m_tlast,
    output logic         m_tuser     // chunk_start
);

    rwcp_pkg::push_t push;
    logic            room;
    logic            accept;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    rwcp_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .file_byte   (s_tdata),
        .end_of_file (s_tlast),
        .push        (push)
    );

    rwcp_out_queue u_out_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: verif/tb_riff_wave_chunk_parser.sv
`timescale 1ns / 1ps

module tb_riff_wave_chunk_parser;

    localparam int SIZE_BITS = 32;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload;
        logic        chunk_start;
        logic [15:0] format_tag;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic [1:0]  status;
    } wav_word_t;

    class wav_chunk_walker;
        wav_word_t         pending_words[$];
        int                errors;
        logic [3:0]        bytes_seen;
        bit                header_good;
        rwcp_pkg::phase_t  parse_step;
        logic [2:0]        header_index;
        logic [31:0]       chunk_id;
        logic [31:0]       chunk_size;
        logic [31:0]       body_left;
        bit                pad_due;
        logic [7:0]        fmt_bytes[16];
        logic [15:0]       kept_tag;
        logic [15:0]       kept_channels;
        logic [31:0]       kept_srate;
        logic [31:0]       kept_brate;
        logic [15:0]       kept_align;
        logic [15:0]       kept_bits;
        bit                have_format;
        bit                have_payload;

        function new();
            errors = 0;
            restart_file();
        endfunction

        function void restart_file();
            bytes_seen    = '0;
            header_good   = 1'b1;
            parse_step    = rwcp_pkg::PH_FILE;
            header_index  = '0;
            chunk_id      = '0;
            chunk_size    = '0;
            body_left     = '0;
            pad_due       = 1'b0;
            foreach (fmt_bytes[i]) fmt_bytes[i] = '0;
            kept_tag      = '0;
            kept_channels = '0;
            kept_srate    = '0;
            kept_brate    = '0;
            kept_align    = '0;
            kept_bits     = '0;
            have_format   = 1'b0;
            have_payload  = 1'b0;
        endfunction

        function void close_body();
            parse_step   = pad_due ? rwcp_pkg::PH_PAD : rwcp_pkg::PH_HDR;
            header_index = '0;
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function void take_byte(logic [7:0] b, bit eof);
            wav_word_t   w;
            logic [31:0] tag;
            logic [31:0] off;
            logic [63:0] size_mask;
            size_mask = (64'd1 << SIZE_BITS) - 64'd1;
            case (parse_step)
                rwcp_pkg::PH_FILE:
                begin
                    if (bytes_seen < 4 || (bytes_seen >= 8 && bytes_seen < 12))
                    begin
                        tag = (bytes_seen < 4) ? rwcp_pkg::TAG_RIFF : rwcp_pkg::TAG_WAVE;
                        if (8'(tag >> (8 * (3 - bytes_seen[1:0]))) != b)
                            header_good = 1'b0;
                    end
                    if (bytes_seen == rwcp_pkg::HDR_LAST_POS)
                    begin
                        parse_step   = rwcp_pkg::PH_HDR;
                        header_index = '0;
                    end
                end
                rwcp_pkg::PH_HDR:
                begin
                    if (header_index < 4)
                    begin
                        chunk_id = {chunk_id[23:0], b};
                        if (header_index == 0)
                            chunk_size = '0;
                    end
                    else
                        chunk_size |= 32'(b) << (8 * (header_index - 3'd4));
                    header_index = header_index + 3'd1;
                    if (header_index == 0)
                    begin
                        chunk_size = chunk_size & size_mask[31:0];
                        body_left  = chunk_size;
                        pad_due    = chunk_size[0];
                        if (chunk_id == rwcp_pkg::TAG_DATA)
                            have_payload = 1'b1;
                        if (chunk_size == 0)
                            close_body();
                        else
                            parse_step = rwcp_pkg::PH_BODY;
                    end
                end
                rwcp_pkg::PH_BODY:
                begin
                    off = chunk_size - body_left;
                    if (chunk_id == rwcp_pkg::TAG_FMT && chunk_size >= rwcp_pkg::FMT_MIN &&
                        off < rwcp_pkg::FMT_MIN)
                    begin
                        fmt_bytes[off[3:0]] = b;
                        if (off == rwcp_pkg::FMT_MIN - 1)
                        begin
                            kept_tag      = {fmt_bytes[1], fmt_bytes[0]};
                            kept_channels = {fmt_bytes[3], fmt_bytes[2]};
                            kept_srate    = {fmt_bytes[7], fmt_bytes[6], fmt_bytes[5],
                                             fmt_bytes[4]};
                            kept_brate    = {fmt_bytes[11], fmt_bytes[10], fmt_bytes[9],
                                             fmt_bytes[8]};
                            kept_align    = {fmt_bytes[13], fmt_bytes[12]};
                            kept_bits     = {fmt_bytes[15], fmt_bytes[14]};
                            have_format   = 1'b1;
                        end
                    end
                    else if (chunk_id == rwcp_pkg::TAG_DATA && header_good)
                    begin
                        w             = '0;
                        w.kind        = rwcp_pkg::KIND_PAYLOAD;
                        w.payload     = b;
                        w.chunk_start = (off == 0);
                        pending_words.push_back(w);
                    end
                    body_left = body_left - 32'd1;
                    if (body_left == 0)
                        close_body();
                end
                default:
                begin
                    parse_step   = rwcp_pkg::PH_HDR;
                    header_index = '0;
                end
            endcase
            if (bytes_seen < rwcp_pkg::SEEN_MAX)
                bytes_seen = bytes_seen + 4'd1;
            if (eof)
            begin
                w      = '0;
                w.kind = rwcp_pkg::KIND_REPORT;
                if (!header_good || bytes_seen <= rwcp_pkg::FILE_HDR)
                    w.status = rwcp_pkg::ST_BAD_HEADER;
                else if (!have_format)
                    w.status = rwcp_pkg::ST_NO_FMT;
                else if (!have_payload)
                    w.status = rwcp_pkg::ST_NO_DATA;
                else
                    w.status = rwcp_pkg::ST_OK;
                if (w.status != rwcp_pkg::ST_BAD_HEADER)
                begin
                    w.format_tag    = kept_tag;
                    w.channel_count = kept_channels;
                    w.sample_rate   = kept_srate;
                    w.byte_rate     = kept_brate;
                    w.block_align   = kept_align;
                    w.sample_bits   = kept_bits;
                end
                pending_words.push_back(w);
                restart_file();
            end
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v,
                         act_v);
                errors++;
            end
        endfunction

        function void check_word(logic [143:0] data, logic last, logic user);
            wav_word_t e;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual data %0h last %0b",
                         $time, data, last);
                errors++;
                return;
            end
            e = pending_words.pop_front();
            compare_field("kind", e.kind, last);
            compare_field("payload_byte", e.payload, data[7:0]);
            compare_field("chunk_start", e.chunk_start, user);
            compare_field("format_tag", e.format_tag, data[23:8]);
            compare_field("channel_count", e.channel_count, data[39:24]);
            compare_field("sample_rate", e.sample_rate, data[71:40]);
            compare_field("byte_rate", e.byte_rate, data[103:72]);
            compare_field("block_align", e.block_align, data[119:104]);
            compare_field("sample_bits", e.sample_bits, data[135:120]);
            compare_field("status", e.status, data[137:136]);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [143:0] m_tdata;
    logic         m_tlast;
    logic         m_tuser;

    wav_chunk_walker walker;
    logic [7:0]      file_q[$];
    bit              tx_calm;
    bit              rx_calm;
    int              bytes_sent;
    int              file_idx;

    riff_wave_chunk_parser #(
        .SIZE_BITS(SIZE_BITS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic void put_tag(logic [31:0] t);
        for (int i = 3; i >= 0; i--)
            file_q.push_back(t[8*i +: 8]);
    endfunction

    function automatic void put_le32(logic [31:0] v);
        for (int i = 0; i < 4; i++)
            file_q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_chunk(logic [31:0] id, int unsigned size);
        put_tag(id);
        put_le32(size);
        for (int unsigned i = 0; i < size; i++)
            file_q.push_back(8'($urandom));
        if (size % 2 == 1)
            file_q.push_back(8'($urandom));
    endfunction

    function automatic logic [31:0] other_id();
        return $urandom_range(0, 1) ? 32'h4C49_5354 : $urandom;
    endfunction

    // one file per scene: good, extras, bad tag, short, no fmt, no data,
    // neither, cut anywhere, huge last chunk, empty data and short fmt
    function automatic void build_file(int scene);
        logic [31:0] riff_tag;
        logic [31:0] wave_tag;
        logic [31:0] huge_id;
        int          cut;
        file_q.delete();
        riff_tag = rwcp_pkg::TAG_RIFF;
        wave_tag = rwcp_pkg::TAG_WAVE;
        if (scene == 2)
        begin
            if ($urandom_range(0, 1))
                riff_tag ^= 32'd1 << $urandom_range(0, 31);
            else
                wave_tag ^= 32'd1 << $urandom_range(0, 31);
        end
        put_tag(riff_tag);
        put_le32($urandom);
        put_tag(wave_tag);
        if (scene == 6 || $urandom_range(0, 4) == 0)
            put_chunk(other_id(), $urandom_range(0, 5));
        if (scene == 9)
            put_chunk(rwcp_pkg::TAG_FMT, $urandom_range(1, 15));
        if (scene != 4 && scene != 6)
            put_chunk(rwcp_pkg::TAG_FMT, scene == 1 ? $urandom_range(16, 20) : 16);
        if (scene == 1)
        begin
            put_chunk(rwcp_pkg::TAG_DATA, $urandom_range(1, 6));
            put_chunk(other_id(), $urandom_range(0, 3));
            put_chunk(rwcp_pkg::TAG_FMT, 16);
        end
        if (scene == 9)
            put_chunk(rwcp_pkg::TAG_DATA, 0);
        if (scene != 5 && scene != 6)
            put_chunk(rwcp_pkg::TAG_DATA, $urandom_range(0, 9));
        if (scene == 8)
        begin
            case ($urandom_range(0, 2))
                0:       huge_id = rwcp_pkg::TAG_FMT;
                1:       huge_id = rwcp_pkg::TAG_DATA;
                default: huge_id = other_id();
            endcase
            put_tag(huge_id);
            put_le32({8'($urandom_range(1, 255)), 24'($urandom)});
            cut = $urandom_range(0, 20);
            repeat (cut) file_q.push_back(8'($urandom));
        end
        cut = file_q.size();
        if (scene == 3)
            cut = $urandom_range(1, 13);
        else if (scene == 7)
            cut = $urandom_range(13, file_q.size());
        while (file_q.size() > cut)
            void'(file_q.pop_back());
    endfunction

    task automatic send_byte(logic [7:0] b, bit eof);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eof;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        walker.take_byte(b, eof);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
            send_byte(file_q[i], i == file_q.size() - 1);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (walker.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int stall_left;
        m_tready   <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                walker.check_word(m_tdata, m_tlast, m_tuser);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap(1'b0);
            end
        end
    end

    initial
    begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        walker     = new();
        tx_calm    = 1'b0;
        rx_calm    = 1'b0;
        bytes_sent = 0;
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= 8'h00;
        s_tlast    <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-byte files, bare header, header with a bad tag
        file_q = '{8'h00};
        send_file();
        file_q = '{8'hFF};
        send_file();
        file_q.delete();
        put_tag(rwcp_pkg::TAG_RIFF);
        put_le32(32'hFFFF_FFFF);
        put_tag(rwcp_pkg::TAG_WAVE);
        send_file();
        file_q.delete();
        put_tag(rwcp_pkg::TAG_RIFF);
        put_le32(32'h0000_0000);
        put_tag(rwcp_pkg::TAG_WAVE ^ 32'h0000_00FF);
        file_q.push_back(8'h00);
        send_file();
        drain_results();

        file_idx = 0;
        while (bytes_sent < 750)
        begin
            tx_calm = ($urandom_range(0, 2) == 0);
            rx_calm = ($urandom_range(0, 2) == 0);
            build_file(file_idx % 10);
            send_file();
            file_idx++;
            if (file_idx % 7 == 0)
                drain_results();
        end
        drain_results();
        repeat (20) @(posedge clk);

        if (walker.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
